// ===== hw/rtl/declaration_table_chained_insert_defines.svh =====
// Assertion macros used by the declaration table RTL.
`ifndef DECLARATION_TABLE_CHAINED_INSERT_DEFINES_SVH
`define DECLARATION_TABLE_CHAINED_INSERT_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define DTCI_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("declaration table assertion failed");

// Next-cycle implication, sampled on the block clock, off during reset.
`define DTCI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("declaration table assertion failed");

`endif

// ===== hw/rtl/dtci_pkg.sv =====
// Types and constants of the declaration table insert engine.
package dtci_pkg;

   localparam int TABLE_DEPTH   = 1024;
   localparam int OVERFLOW_BASE = 512;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int HOME_W        = $clog2(OVERFLOW_BASE);
   localparam int KIND_W        = 3;
   localparam int LEX_W         = 9;
   localparam int REGION_W      = 8;
   localparam int DESC_W        = 10;
   localparam int SIZE_W        = 16;
   localparam int COUNT_W       = 10;
   localparam int NUM_BASE      = 4;

   localparam logic [KIND_W-1:0] KIND_STRUCT    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ARRAY     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_VARIABLE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PROCEDURE = 3'd3;

   typedef struct packed {
      logic                used;
      logic [KIND_W-1:0]   kind;
      logic                linked;
      logic [IDX_W-1:0]    link;
      logic [REGION_W-1:0] region;
      logic [DESC_W-1:0]   description;
      logic [SIZE_W-1:0]   size;
   } decl_entry_type;

   typedef struct packed {
      logic           en;
      logic [IDX_W-1:0] addr;
      decl_entry_type data;
   } mem_wr_type;

endpackage

// ===== hw/rtl/dtci_table.sv =====
// Declaration store: one write port and one registered read port.
module dtci_table
   import dtci_pkg::*;
(
   input  logic             clock,
   input  mem_wr_type       wr,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output decl_entry_type   rd_data
);

   decl_entry_type mem [TABLE_DEPTH];
   decl_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/declaration_table_chained_insert.sv =====
// Declaration table insert engine: a primary slot per lexeme plus a chained overflow area.
// A transaction is accepted from IDLE, its primary slot is read in FETCH, and EXAM answers
// when that slot is free or the overflow area is full; otherwise FETCH and EXAM repeat per
// chain link, then LINK patches the tail and answers. A new transaction waits for busy low.
// Reset: a clearing pass over the 512 primary slots, busy held high meanwhile.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall them.
`include "declaration_table_chained_insert_defines.svh"

module declaration_table_chained_insert
   import dtci_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [LEX_W-1:0]    req_lexeme,
   input  logic [REGION_W-1:0] req_region,
   input  logic [DESC_W-1:0]   req_description,
   input  logic [SIZE_W-1:0]   req_size_or_offset,
   output logic                rsp_valid,
   output logic [IDX_W-1:0]    rsp_slot,
   output logic                rsp_in_overflow,
   output logic                rsp_full_res,
   output logic [COUNT_W-1:0]  rsp_primary_count
);

   // The sequencer walks the chain one link at a time: FETCH issues a table read,
   // EXAM looks at the returned entry and either follows the link or finishes.
   // LINK patches the tail entry of the chain once the new entry is written.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_EXAM,
      ST_LINK
   } state_type;

   state_type           state_ff;
   logic [HOME_W-1:0]   clr_ff;
   logic [IDX_W-1:0]    addr_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [REGION_W-1:0] region_ff;
   logic [DESC_W-1:0]   desc_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [IDX_W:0]      ovf_next_ff;
   logic [COUNT_W-1:0]  prim_cnt_ff;
   logic                rsp_valid_ff;
   logic [IDX_W-1:0]    rsp_slot_ff;
   logic                rsp_ovf_ff;
   logic                rsp_full_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   mem_wr_type          wr;
   logic                rd_en;
   decl_entry_type      rd_data;
   logic                ovf_full;
   decl_entry_type      new_entry;
   decl_entry_type      link_entry;

   // Base types occupy the first slots after reset; every other primary slot is empty.
   function automatic decl_entry_type base_entry(input logic [HOME_W-1:0] idx);
      decl_entry_type e;
      e = '0;
      if (idx < HOME_W'(NUM_BASE)) begin
         e.used        = 1'b1;
         e.kind        = KIND_W'(idx);
         e.description = '1;
         e.size        = (idx == HOME_W'(KIND_PROCEDURE)) ? SIZE_W'(1) : SIZE_W'(4);
      end
      return e;
   endfunction

   // The overflow area is exhausted once the next free index reaches the table depth.
   assign ovf_full = ovf_next_ff[IDX_W];

   // A new entry goes to the primary slot when it is free; in overflow, struct and
   // array entries keep no size.
   always_comb begin
      new_entry             = '0;
      new_entry.used        = 1'b1;
      new_entry.kind        = kind_ff;
      new_entry.region      = region_ff;
      new_entry.description = desc_ff;
      new_entry.size        = size_ff;
      if (rd_data.used && (kind_ff == KIND_STRUCT || kind_ff == KIND_ARRAY)) begin
         new_entry.size = '0;
      end
   end

   always_comb begin
      link_entry        = rd_data;
      link_entry.linked = 1'b1;
      link_entry.link   = ovf_next_ff[IDX_W-1:0];
   end

   // Single write port: clearing pass, new entry, or the tail link patch.
   always_comb begin
      wr    = '0;
      rd_en = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr.en   = 1'b1;
            wr.addr = IDX_W'(clr_ff);
            wr.data = base_entry(clr_ff);
         end
         ST_FETCH: begin
            rd_en = 1'b1;
         end
         ST_EXAM: begin
            if (!rd_data.used) begin
               wr.en   = 1'b1;
               wr.addr = addr_ff;
               wr.data = new_entry;
            end else if (!ovf_full && !rd_data.linked) begin
               wr.en   = 1'b1;
               wr.addr = ovf_next_ff[IDX_W-1:0];
               wr.data = new_entry;
            end
         end
         ST_LINK: begin
            wr.en   = 1'b1;
            wr.addr = addr_ff;
            wr.data = link_entry;
         end
         default: begin
         end
      endcase
   end

   dtci_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ovf_next_ff  <= (IDX_W + 1)'(OVERFLOW_BASE);
         prim_cnt_ff  <= COUNT_W'(NUM_BASE);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == HOME_W'(OVERFLOW_BASE - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  // The primary slot is the lexeme taken modulo the primary area size.
                  addr_ff   <= IDX_W'(req_lexeme[HOME_W-1:0]);
                  kind_ff   <= req_kind;
                  region_ff <= req_region;
                  desc_ff   <= req_description;
                  size_ff   <= req_size_or_offset;
                  state_ff  <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_EXAM;
            end
            ST_EXAM: begin
               if (!rd_data.used) begin
                  prim_cnt_ff     <= prim_cnt_ff + 1'b1;
                  rsp_valid_ff    <= 1'b1;
                  rsp_slot_ff     <= addr_ff;
                  rsp_ovf_ff      <= 1'b0;
                  rsp_full_ff     <= 1'b0;
                  rsp_count_ff    <= prim_cnt_ff + 1'b1;
                  state_ff        <= ST_IDLE;
               end else if (ovf_full) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_slot_ff     <= '0;
                  rsp_ovf_ff      <= 1'b0;
                  rsp_full_ff     <= 1'b1;
                  rsp_count_ff    <= prim_cnt_ff;
                  state_ff        <= ST_IDLE;
               end else if (rd_data.linked) begin
                  addr_ff  <= rd_data.link;
                  state_ff <= ST_FETCH;
               end else begin
                  state_ff <= ST_LINK;
               end
            end
            ST_LINK: begin
               ovf_next_ff  <= ovf_next_ff + 1'b1;
               rsp_valid_ff <= 1'b1;
               rsp_slot_ff  <= ovf_next_ff[IDX_W-1:0];
               rsp_ovf_ff   <= 1'b1;
               rsp_full_ff  <= 1'b0;
               rsp_count_ff <= prim_cnt_ff;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_in_overflow   = rsp_ovf_ff;
   assign rsp_full_res      = rsp_full_ff;
   assign rsp_primary_count = rsp_count_ff;

   `DTCI_ASSERT_NOW(a_ovf_excl_full, rsp_valid, !(rsp_in_overflow && rsp_full_res))
   `DTCI_ASSERT_NOW(a_ovf_slot_range, rsp_valid && rsp_in_overflow, rsp_slot >= IDX_W'(OVERFLOW_BASE))
   `DTCI_ASSERT_NOW(a_full_only_when_exhausted, rsp_valid && rsp_full_res, ovf_full)
   `DTCI_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)

endmodule

// ===== bench/tb_declaration_table_chained_insert.sv =====
// Self-checking testbench for the declaration table insert engine.
`timescale 1ns / 100ps

module tb_declaration_table_chained_insert;
   import dtci_pkg::*;

   // The package names the first four declaration kinds. The function kind and the three
   // undefined codes are named here so that the stimulus table can use them by name.
   localparam logic [KIND_W-1:0] KIND_FUNCTION = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SPARE5   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE6   = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE7   = 3'd7;

   localparam int RANDOM_ITEMS   = 900;
   localparam int RANDOM_CAP     = 2500;
   localparam int REFUSED_WANTED = 40;
   localparam int HOT_COUNT      = 16;
   localparam int TAIL_CYCLES    = 16;
   // The longest quiet stretch of a correct run is the clearing pass after reset or a walk
   // down the longest possible chain, plus a sender gap. The limit is several times that.
   localparam int WATCHDOG_LIMIT = 6000;

   // One insert transaction as it is presented on the req_ ports.
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [LEX_W-1:0]    lexeme;
      logic [REGION_W-1:0] region;
      logic [DESC_W-1:0]   description;
      logic [SIZE_W-1:0]   size_or_offset;
   } decl_insert_type;

   // What the engine reports for one insert transaction.
   typedef struct packed {
      logic [IDX_W-1:0]   slot;
      logic               in_overflow;
      logic               full;
      logic [COUNT_W-1:0] primary_count;
   } insert_outcome_type;

   // A row of the directed table. When pinned is set, the outcome in the row is the
   // expected result; otherwise the outcome is left zero and the predictor supplies it.
   typedef struct packed {
      decl_insert_type    cmd;
      logic               pinned;
      insert_outcome_type outcome;
   } directed_row_type;

   // The directed rows walk through every kind, the field extremes, chains that grow
   // behind the base types and behind fresh primary slots, the highest lexeme, and the
   // undefined kind codes both in a primary slot and in the overflow area. The first
   // four rows follow directly from the table contents right after reset.
   localparam directed_row_type DIRECTED [18] = '{
      '{'{KIND_STRUCT,    9'd0,   8'd0,   10'd0,    16'd0},     1'b1,
        '{10'd512, 1'b1, 1'b0, 10'd4}},
      '{'{KIND_ARRAY,     9'd0,   8'd255, 10'd1023, 16'hFFFF},  1'b1,
        '{10'd513, 1'b1, 1'b0, 10'd4}},
      '{'{KIND_VARIABLE,  9'd4,   8'd0,   10'd0,    16'd0},     1'b1,
        '{10'd4,   1'b0, 1'b0, 10'd5}},
      '{'{KIND_PROCEDURE, 9'd511, 8'd255, 10'd1023, 16'hFFFF},  1'b1,
        '{10'd511, 1'b0, 1'b0, 10'd6}},
      '{'{KIND_FUNCTION,  9'd511, 8'h55,  10'h2AA,  16'hAAAA},  1'b0, '0},
      '{'{KIND_SPARE5,    9'd1,   8'hAA,  10'h155,  16'h5555},  1'b0, '0},
      '{'{KIND_SPARE6,    9'd2,   8'd17,  10'd300,  16'd4096},  1'b0, '0},
      '{'{KIND_SPARE7,    9'd3,   8'd200, 10'd999,  16'd7},     1'b0, '0},
      '{'{KIND_SPARE5,    9'd256, 8'd3,   10'd3,    16'd3},     1'b0, '0},
      '{'{KIND_STRUCT,    9'd256, 8'd9,   10'd512,  16'd1234},  1'b0, '0},
      '{'{KIND_ARRAY,     9'd0,   8'd1,   10'd2,    16'd800},   1'b0, '0},
      '{'{KIND_VARIABLE,  9'd0,   8'd2,   10'd4,    16'd16},    1'b0, '0},
      '{'{KIND_PROCEDURE, 9'd0,   8'd4,   10'd8,    16'd32},    1'b0, '0},
      '{'{KIND_FUNCTION,  9'd255, 8'd128, 10'd511,  16'h8000},  1'b0, '0},
      '{'{KIND_SPARE7,    9'd5,   8'd1,   10'd1,    16'd1},     1'b0, '0},
      '{'{KIND_VARIABLE,  9'd5,   8'd254, 10'd1022, 16'hFFFE},  1'b0, '0},
      '{'{KIND_STRUCT,    9'd510, 8'd64,  10'd64,   16'd64},    1'b0, '0},
      '{'{KIND_ARRAY,     9'd510, 8'd255, 10'd1023, 16'hFFFF},  1'b0, '0}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [LEX_W-1:0]    req_lexeme = '0;
   logic [REGION_W-1:0] req_region = '0;
   logic [DESC_W-1:0]   req_description = '0;
   logic [SIZE_W-1:0]   req_size_or_offset = '0;
   logic                rsp_valid;
   logic [IDX_W-1:0]    rsp_slot;
   logic                rsp_in_overflow;
   logic                rsp_full_res;
   logic [COUNT_W-1:0]  rsp_primary_count;

   declaration_table_chained_insert u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_lexeme         (req_lexeme),
      .req_region         (req_region),
      .req_description    (req_description),
      .req_size_or_offset (req_size_or_offset),
      .rsp_valid          (rsp_valid),
      .rsp_slot           (rsp_slot),
      .rsp_in_overflow    (rsp_in_overflow),
      .rsp_full_res       (rsp_full_res),
      .rsp_primary_count  (rsp_primary_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Shadow copy of the table occupancy. Only which slots are taken, where the next
   // overflow entry goes and the primary tally can be seen on the result ports: the new
   // entry always lands at the overflow cursor, whichever chain tail it is linked behind,
   // so the links and the stored fields need not be kept here.
   bit                 slot_taken [TABLE_DEPTH];
   int unsigned        overflow_cursor;
   logic [COUNT_W-1:0] primary_tally;
   int unsigned        n_primary;
   int unsigned        n_chained;
   int unsigned        n_refused;

   // Expected outcomes of accepted transactions, oldest first.
   insert_outcome_type pending_outcomes [$];
   int unsigned        mismatches;
   int unsigned        burst_left;

   // Applies one insert to the shadow table and returns what the engine should report.
   function automatic insert_outcome_type predict_insert(decl_insert_type c);
      int unsigned        home;
      insert_outcome_type r;
      home = int'(c.lexeme) % OVERFLOW_BASE;
      if (home >= TABLE_DEPTH) begin
         home = home % TABLE_DEPTH;
      end
      r = '0;
      if (!slot_taken[home]) begin
         // A free primary slot takes the declaration and the tally goes up by one.
         slot_taken[home] = 1'b1;
         primary_tally = primary_tally + 1'b1;
         r.slot = IDX_W'(home);
         n_primary++;
      end else if (overflow_cursor >= TABLE_DEPTH) begin
         // The overflow area is used up: nothing is written and slot reads zero.
         r.full = 1'b1;
         n_refused++;
      end else begin
         slot_taken[overflow_cursor] = 1'b1;
         r.slot = IDX_W'(overflow_cursor);
         r.in_overflow = 1'b1;
         overflow_cursor++;
         n_chained++;
      end
      r.primary_count = primary_tally;
      return r;
   endfunction

   // Presents one transaction and holds it until the engine takes it. The item is taken
   // at the first rising edge where start is high and busy is low; only then is its
   // outcome predicted and queued. A pinned outcome from the directed table replaces the
   // predicted one, but the shadow table is updated either way.
   task automatic issue_insert(input decl_insert_type c, input logic pinned,
                               input insert_outcome_type pinned_outcome);
      insert_outcome_type predicted;
      start              <= 1'b1;
      req_kind           <= c.kind;
      req_lexeme         <= c.lexeme;
      req_region         <= c.region;
      req_description    <= c.description;
      req_size_or_offset <= c.size_or_offset;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = predict_insert(c);
      pending_outcomes.push_back(pinned ? pinned_outcome : predicted);
   endtask

   // The sender works in bursts. Inside a burst the next transaction follows at once; at
   // the end of a burst start drops for a random number of cycles. Since the engine's
   // latency changes with the chain length, the gaps land on every phase of its work.
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   // Stops sending and waits until every outstanding transaction has reported.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Result checker. The engine strobes each result for one cycle and cannot be held
   // off, so every strobe is compared against the oldest expectation right away.
   always @(posedge clock) begin
      insert_outcome_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result: slot %0d with no transaction outstanding", rsp_slot);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_slot !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
               mismatches++;
            end
            if (rsp_in_overflow !== want.in_overflow) begin
               $error("in_overflow: expected %0d, got %0d", want.in_overflow, rsp_in_overflow);
               mismatches++;
            end
            if (rsp_full_res !== want.full) begin
               $error("full_res: expected %0d, got %0d", want.full, rsp_full_res);
               mismatches++;
            end
            if (rsp_primary_count !== want.primary_count) begin
               $error("primary_count: expected %0d, got %0d",
                      want.primary_count, rsp_primary_count);
               mismatches++;
            end
         end
      end
   end

   // Watchdog. Any cycle in which a transaction is taken or a result is strobed counts
   // as progress; a long enough stretch without either ends the run as a failure.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("declaration_table_chained_insert: mismatch");
      $finish;
   end

   // Main stimulus.
   initial begin
      decl_insert_type item;
      int unsigned     hot_lexemes [HOT_COUNT];
      int unsigned     random_sent;

      // After reset the table holds the four base types in slots 0 to 3.
      foreach (slot_taken[i]) begin
         slot_taken[i] = (i < NUM_BASE);
      end
      overflow_cursor = OVERFLOW_BASE;
      primary_tally   = COUNT_W'(NUM_BASE);
      n_primary       = 0;
      n_chained       = 0;
      n_refused       = 0;
      mismatches      = 0;
      burst_left      = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The first transaction is offered right away, so it waits out the
      // clearing pass that the engine runs after reset.
      foreach (DIRECTED[i]) begin
         issue_insert(DIRECTED[i].cmd, DIRECTED[i].pinned, DIRECTED[i].outcome);
         pace_sender();
      end

      // Random part. About half of the transactions reuse a small set of hot lexemes, so
      // their chains grow long and the overflow area runs out well before the end; the
      // rest spread over all lexemes and fill the primary slots. The part goes on past
      // its nominal length until a few dozen refusals on a full table have been seen or the cap is hit.
      foreach (hot_lexemes[i]) begin
         hot_lexemes[i] = $urandom_range(0, 2 ** LEX_W - 1);
      end
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS ||
             (n_refused < REFUSED_WANTED && random_sent < RANDOM_CAP)) begin
         item.kind = KIND_W'($urandom_range(0, 2 ** KIND_W - 1));
         if ($urandom_range(0, 99) < 55) begin
            item.lexeme = LEX_W'(hot_lexemes[$urandom_range(0, HOT_COUNT - 1)]);
         end else begin
            item.lexeme = LEX_W'($urandom_range(0, 2 ** LEX_W - 1));
         end
         item.region         = REGION_W'($urandom_range(0, 2 ** REGION_W - 1));
         item.description    = DESC_W'($urandom_range(0, 2 ** DESC_W - 1));
         item.size_or_offset = SIZE_W'($urandom_range(0, 2 ** SIZE_W - 1));
         issue_insert(item, 1'b0, '0);
         random_sent++;
         // Halfway through, the sender holds off until the engine has answered everything.
         if (random_sent == RANDOM_ITEMS / 2) begin
            drain_results();
         end else begin
            pace_sender();
         end
      end

      // Wait for the last results, then a few more cycles to catch any stray strobe.
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Inserted %0d declarations: %0d directed and %0d random.",
               $size(DIRECTED) + random_sent, $size(DIRECTED), random_sent);
      $display("Of these %0d took a primary slot, %0d were chained into overflow,",
               n_primary, n_chained);
      $display("and %0d hit a full table.", n_refused);
      if (mismatches == 0) begin
         $display("declaration_table_chained_insert: match");
      end else begin
         $display("declaration_table_chained_insert: mismatch");
      end
      $finish;
   end

endmodule
